FILE: sv/assert_macros.svh
// Assertion macros shared by the note mixer RTL.
// Included by every module that checks its own logic; needs no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

FILE: sv/etsm_pkg.sv
// Types and constants of the equal-tempered sine note mixer.
// Used by every module of the block but etsm_fifo; depends on nothing.
`default_nettype none
package etsm_pkg;

	localparam int ROOT_FREQ_CENTIHZ_DEF = 26163;
	localparam int SAMPLE_RATE_HZ_DEF    = 48000;
	localparam int SINE_TABLE_BITS_DEF   = 10;
	localparam int QUEUE_DEPTH_DEF       = 2;

	localparam int FRAME_W    = 32;
	localparam int SAMPLE_W   = 16;
	localparam int MAG_W      = 15;
	localparam int SEMITONE_W = 6;
	localparam int AMP_W      = 15;
	localparam int INC_W      = 32;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;
	localparam int SEMITONE_CODES = 1 << SEMITONE_W;

	localparam logic [CFG_INDEX_W-1:0] CFG_SEMITONE  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE = 8'd1;
	localparam logic [AMP_W-1:0] AMP_RESET = 15'd16384;

	localparam logic [63:0] SEMITONE_RATIO [12] = '{
		64'd65536, 64'd69433, 64'd73562, 64'd77936, 64'd82570, 64'd87480,
		64'd92682, 64'd98193, 64'd104032, 64'd110218, 64'd116772, 64'd123715
	};

	localparam logic [63:0] POLY_C1 = 64'd1686629713;
	localparam logic [63:0] POLY_C3 = 64'd693598668;
	localparam logic [63:0] POLY_C5 = 64'd85569306;
	localparam logic [63:0] POLY_C7 = 64'd5026995;
	localparam logic [63:0] POLY_C9 = 64'd172272;

	typedef struct packed {
		logic [FRAME_W-1:0]        frame_index;
		logic signed [SAMPLE_W-1:0] mix_in;
		logic                      last_in_buffer;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mix_out;
		logic                      saturated;
		logic                      last_out;
	} result_t;

	typedef struct packed {
		logic [INC_W-1:0] inc;
		logic [AMP_W-1:0] amplitude;
	} note_cfg_t;

endpackage
`default_nettype wire

FILE: sv/equal_tempered_sine_note_mixer.sv
// Top level of the equal-tempered sine note mixer.
// Depends on etsm_pkg, etsm_front, etsm_back and etsm_fifo.
`default_nettype none
// Adds one sine note a whole number of semitones above the root into a stream
// of mix samples. Each sample is pushed with its absolute frame index and
// comes out, mixed and saturated, in order on the result queue. The block takes
// one sample per clock and delivers one per clock as long as results are
// popped; a sample goes through the input queue and stages s1, s2, s3. The
// phase multiplier, the sine table read and the gain multiplier each take one
// pipeline stage; the input and output queues let either side stall. The user
// must write configuration through the cfg port only while no samples are in
// flight (not enforced); a semitone write looks up the phase increment at once.
module equal_tempered_sine_note_mixer #(
	parameter int ROOT_FREQ_CENTIHZ = etsm_pkg::ROOT_FREQ_CENTIHZ_DEF,
	parameter int SAMPLE_RATE_HZ    = etsm_pkg::SAMPLE_RATE_HZ_DEF,
	parameter int SINE_TABLE_BITS   = etsm_pkg::SINE_TABLE_BITS_DEF,
	parameter int QUEUE_DEPTH       = etsm_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire etsm_pkg::sample_t               sample,
	output logic                                 empty,
	input  wire logic                            pop,
	output etsm_pkg::result_t                    result,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [etsm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [etsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import etsm_pkg::*;

	logic      q_pop;
	logic      q_empty;
	sample_t   q_item;
	note_cfg_t note_cfg;
	logic      out_full;
	logic      out_push;
	result_t   out_item;

	etsm_front #(
		.ROOT_FREQ_CENTIHZ (ROOT_FREQ_CENTIHZ),
		.SAMPLE_RATE_HZ    (SAMPLE_RATE_HZ),
		.QUEUE_DEPTH       (QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_pop     (q_pop),
		.q_empty   (q_empty),
		.q_item    (q_item),
		.note_cfg  (note_cfg)
	);

	etsm_back #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.note_cfg (note_cfg),
		.out_full (out_full),
		.out_push (out_push),
		.out_item (out_item)
	);

	etsm_fifo #(
		.T     (result_t),
		.DEPTH (QUEUE_DEPTH)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_item),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule
`default_nettype wire

FILE: sv/etsm_fifo.sv
// Small register queue with push/full and pop/empty sides.
// Generic over the item type; uses the shared assertion macros.
`default_nettype none
`include "assert_macros.svh"
module etsm_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire T     wr_data,
	output logic      full,
	input  wire logic rd_en,
	output T          rd_data,
	output logic      empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	T                 mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	`ASSERT_PROP(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH), "queue count overflow")
	`ASSERT_PROP(a_count_inc, clk, arst_n, (do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1), "queue count did not rise on transfer in")
	`ASSERT_PROP(a_count_dec, clk, arst_n, (do_rd && !do_wr) |=> (count_q == $past(count_q) - 1'b1), "queue count did not fall on transfer out")

endmodule
`default_nettype wire

FILE: sv/etsm_sine_rom.sv
// Quarter-wave sine magnitude table with registered read.
// Entries are built at elaboration from the polynomial in etsm_pkg.
`default_nettype none
module etsm_sine_rom #(
	parameter int TABLE_BITS = etsm_pkg::SINE_TABLE_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [TABLE_BITS-2:0]      addr,
	output logic [etsm_pkg::MAG_W-1:0]      data
);
	import etsm_pkg::*;

	localparam int QUARTER = 1 << (TABLE_BITS - 2);

	logic [MAG_W-1:0] rom [QUARTER + 1];

	for (genvar j = 0; j <= QUARTER; j++) begin : g_entry
		localparam logic [63:0] U   = 64'(j) << (32 - TABLE_BITS);
		localparam logic [63:0] U2  = (U * U) >> 30;
		localparam logic [63:0] T7  = POLY_C7 - ((U2 * POLY_C9) >> 30);
		localparam logic [63:0] T5  = POLY_C5 - ((U2 * T7) >> 30);
		localparam logic [63:0] T3  = POLY_C3 - ((U2 * T5) >> 30);
		localparam logic [63:0] T1  = POLY_C1 - ((U2 * T3) >> 30);
		localparam logic [63:0] S30 = (U * T1) >> 30;
		localparam logic [63:0] R   = (S30 + 64'd16384) >> 15;
		localparam logic [63:0] VAL = (R > 64'd32767) ? 64'd32767 : R;
		assign rom[j] = VAL[MAG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data <= rom[addr];
		end
	end

endmodule
`default_nettype wire

FILE: sv/etsm_front.sv
// Front end: input queue, configuration registers and increment lookup.
// Depends on etsm_pkg and etsm_fifo.
`default_nettype none
module etsm_front #(
	parameter int ROOT_FREQ_CENTIHZ = etsm_pkg::ROOT_FREQ_CENTIHZ_DEF,
	parameter int SAMPLE_RATE_HZ    = etsm_pkg::SAMPLE_RATE_HZ_DEF,
	parameter int QUEUE_DEPTH       = etsm_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire etsm_pkg::sample_t               sample,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [etsm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [etsm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            q_pop,
	output logic                                 q_empty,
	output etsm_pkg::sample_t                    q_item,
	output etsm_pkg::note_cfg_t                  note_cfg
);
	import etsm_pkg::*;

	localparam logic [63:0] DEN = 64'd100 * 64'(SAMPLE_RATE_HZ);
	localparam logic [63:0] INC_RESET_W =
		(((64'(ROOT_FREQ_CENTIHZ) * SEMITONE_RATIO[0]) << 16) + DEN / 2) / DEN;

	logic [INC_W-1:0] inc_tab [SEMITONE_CODES];
	logic [INC_W-1:0] inc_q;
	logic [AMP_W-1:0] amp_q;
	logic             cfg_wr;

	for (genvar s = 0; s < SEMITONE_CODES; s++) begin : g_inc
		localparam int OCT = s / 12;
		localparam int K   = s % 12;
		localparam logic [63:0] NUM =
			((64'(ROOT_FREQ_CENTIHZ) * SEMITONE_RATIO[K]) << OCT) << 16;
		localparam logic [63:0] INC = (NUM + DEN / 2) / DEN;
		assign inc_tab[s] = INC[INC_W-1:0];
	end

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q <= INC_RESET_W[INC_W-1:0];
			amp_q <= AMP_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_SEMITONE:  inc_q <= inc_tab[cfg_data[SEMITONE_W-1:0]];
				CFG_AMPLITUDE: amp_q <= cfg_data[AMP_W-1:0];
				default: begin
					inc_q <= inc_q;
					amp_q <= amp_q;
				end
			endcase
		end
	end

	assign note_cfg.inc       = inc_q;
	assign note_cfg.amplitude = amp_q;

	etsm_fifo #(
		.T     (sample_t),
		.DEPTH (QUEUE_DEPTH)
	) u_in_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (sample),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_item),
		.empty   (q_empty)
	);

endmodule
`default_nettype wire

FILE: sv/etsm_back.sv
// Back end: phase multiply, sine lookup, gain multiply, saturating add.
// Depends on etsm_pkg, etsm_sine_rom and the shared assertion macros.
`default_nettype none
`include "assert_macros.svh"
module etsm_back #(
	parameter int SINE_TABLE_BITS = etsm_pkg::SINE_TABLE_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_empty,
	input  wire etsm_pkg::sample_t   q_item,
	output logic                     q_pop,
	input  wire etsm_pkg::note_cfg_t note_cfg,
	input  wire logic                out_full,
	output logic                     out_push,
	output etsm_pkg::result_t        out_item
);
	import etsm_pkg::*;

	localparam int B       = SINE_TABLE_BITS;
	localparam int QUARTER = 1 << (B - 2);

	logic                       en;
	logic [INC_W-1:0]           phase_d;

	logic                       v_s1;
	logic [INC_W-1:0]           phase_s1;
	logic signed [SAMPLE_W-1:0] mix_s1;
	logic                       last_s1;

	logic [B-1:0]               index_s1;
	logic [B-3:0]               pos_s1;
	logic [B-2:0]               addr_s1;

	logic                       v_s2;
	logic [MAG_W-1:0]           mag_s2;
	logic                       neg_s2;
	logic signed [SAMPLE_W-1:0] mix_s2;
	logic                       last_s2;

	logic [2*MAG_W-1:0]         gain_prod;

	logic                       v_s3;
	logic [MAG_W-1:0]           scaled_s3;
	logic                       neg_s3;
	logic signed [SAMPLE_W-1:0] mix_s3;
	logic                       last_s3;

	logic signed [SAMPLE_W:0]   wave;
	logic signed [SAMPLE_W:0]   sum;

	assign en       = !(v_s3 && out_full);
	assign q_pop    = en && !q_empty;
	assign out_push = v_s3 && !out_full;

	assign phase_d = q_item.frame_index * note_cfg.inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s1 <= phase_d;
			mix_s1   <= q_item.mix_in;
			last_s1  <= q_item.last_in_buffer;
		end
	end

	assign index_s1 = phase_s1[INC_W-1 -: B];
	assign pos_s1   = index_s1[B-3:0];
	assign addr_s1  = index_s1[B-2] ? ((B-1)'(QUARTER) - {1'b0, pos_s1}) : {1'b0, pos_s1};

	etsm_sine_rom #(
		.TABLE_BITS (B)
	) u_sine_rom (
		.clk  (clk),
		.en   (en),
		.addr (addr_s1),
		.data (mag_s2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2  <= index_s1[B-1];
			mix_s2  <= mix_s1;
			last_s2 <= last_s1;
		end
	end

	assign gain_prod = ((2*MAG_W)'(mag_s2) * (2*MAG_W)'(note_cfg.amplitude))
		+ (2*MAG_W)'(16384);

	always_ff @(posedge clk) begin
		if (en) begin
			scaled_s3 <= gain_prod[2*MAG_W-1:15];
			neg_s3    <= neg_s2;
			mix_s3    <= mix_s2;
			last_s3   <= last_s2;
		end
	end

	always_comb begin
		wave = $signed({2'b00, scaled_s3});
		if (neg_s3) begin
			wave = -wave;
		end
		sum = (SAMPLE_W+1)'(mix_s3) + wave;
		out_item.last_out = last_s3;
		if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
			out_item.saturated = 1'b1;
			out_item.mix_out   = sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
			                                   : {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else begin
			out_item.saturated = 1'b0;
			out_item.mix_out   = sum[SAMPLE_W-1:0];
		end
	end

	`ASSERT_PROP(a_stall_holds, clk, arst_n, (v_s3 && out_full) |=> (v_s3 && $stable(mix_s3) && $stable(scaled_s3)), "stalled result changed")
	`ASSERT_PROP(a_advance, clk, arst_n, (en && v_s2) |=> v_s3, "pipeline lost an item while advancing")
	`ASSERT_PROP(a_pull_lands, clk, arst_n, q_pop |=> v_s1, "pulled item did not enter the pipeline")

endmodule
`default_nettype wire
